// ----- hdl/drt_pkg.sv -----
// Shared constants for the dirty region tracker: command and result codes,
// configuration register indexes, field widths and reset values.
// No dependencies.
package drt_pkg;

  // Input item field widths
  localparam int CMD_W   = 2;
  localparam int IN_CW   = 16;
  localparam int IN_DATA_W = 4 * IN_CW;
  localparam int KIND_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FULL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REGION = 2'd2;

  // Configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd320;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd240;

  // Parameter defaults
  localparam int MAX_REGIONS_DEF = 8;
  localparam int COORD_BITS_DEF  = 12;

endpackage

// ----- hdl/drt_merge.sv -----
// Intersection test and bounding-box merge of a new rectangle with one
// stored entry. Rectangles pack left, top, right, bottom from the lowest bit.
// Depends on nothing but its parameter.
module drt_merge #(
  parameter int COORD_BITS = 12
) (
  input  logic [4*COORD_BITS-1:0] new_rect,
  input  logic [4*COORD_BITS-1:0] ent_rect,
  output logic                    hit,
  output logic [4*COORD_BITS-1:0] merged
);

  localparam int CB = COORD_BITS;

  logic [CB-1:0] nl, nt, nr, nb;
  logic [CB-1:0] el, et, er, eb;

  assign {nb, nr, nt, nl} = new_rect;
  assign {eb, er, et, el} = ent_rect;

  // Overlap on both axes, edges inclusive
  assign hit = (nl <= er) && (el <= nr) && (nt <= eb) && (et <= nb);

  // Bounding box of the two
  assign merged = {(nb > eb) ? nb : eb,
                   (nr > er) ? nr : er,
                   (nt < et) ? nt : et,
                   (nl < el) ? nl : el};

endmodule

// ----- hdl/dirty_region_tracker.sv -----
// Dirty region tracker top level: clamps, merges and stores redraw regions
// in a table with one write and one read port; drains them as a run of results.
// Depends on drt_pkg and drt_merge.
// Add: an add that is dropped or goes into an empty table needs no scan;
//   otherwise entries are scanned one entry per cycle through the table's
//   single read port, up to the first overlap or the last entry. Full repaint needs no scan.
// Drain: the table is read at the accepting edge; each region result is
//   registered from ST_DRAIN, one region per cycle while the output is not
//   stalled; a full-frame or nothing result is registered from ST_EMIT.
// Reset: region count 0, repaint pending set, screen 320 x 240; the table
//   itself is not cleared and needs no clearing pass.
module dirty_region_tracker #(
  parameter int MAX_REGIONS = drt_pkg::MAX_REGIONS_DEF,
  parameter int COORD_BITS  = drt_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [drt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [drt_pkg::CFG_W-1:0]       cfg_wdata,
  // Command stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [drt_pkg::IN_DATA_W-1:0]   in_tdata,   // left, top, right, bottom
  input  logic [drt_pkg::CMD_W-1:0]       in_tuser,   // cmd
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [((4*COORD_BITS+7)/8)*8-1:0] out_tdata, // left, top, right, bottom
  output logic [drt_pkg::KIND_W-1:0]      out_tuser,  // kind
  output logic                            out_tlast   // last
);

  localparam int CB     = COORD_BITS;
  localparam int RW     = 4 * CB;
  localparam int ODW    = ((RW + 7) / 8) * 8;
  localparam int AW     = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW     = $clog2(MAX_REGIONS + 1);
  localparam int SW     = 18;
  localparam int SPAN   = 1 << COORD_BITS;

  localparam logic signed [SW-1:0] SPAN_S = SW'(SPAN);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [RW-1:0] rect_r, rect_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pending_r, pending_nxt;
  logic [drt_pkg::CFG_W-1:0] width_r, height_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [RW-1:0]               out_rect_r, out_rect_nxt;
  logic [drt_pkg::KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic                        out_last_r, out_last_nxt;

  // Region table
  logic [RW-1:0] mem [MAX_REGIONS];
  logic [RW-1:0] rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [RW-1:0] mem_wdata;

  logic                 in_acc;
  logic                 out_free;
  logic signed [SW-1:0] mx_s, my_s, wd_s, ht_s;
  logic signed [SW-1:0] l_s, t_s, r_s, b_s;
  logic signed [SW-1:0] lc_s, tc_s, rc_s, bc_s;
  logic                 rect_empty;
  logic [RW-1:0]        clamped;
  logic [RW-1:0]        full_rect;
  logic                 hit;
  logic [RW-1:0]        merged;
  logic [CW-1:0]        idx_inc;
  logic                 idx_last;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Screen limits: size capped at the coordinate span, minus one
  assign wd_s = SW'(width_r);
  assign ht_s = SW'(height_r);
  assign mx_s = ((wd_s > SPAN_S) ? SPAN_S : wd_s) - SW'(1);
  assign my_s = ((ht_s > SPAN_S) ? SPAN_S : ht_s) - SW'(1);

  // Clamp the incoming rectangle
  assign l_s = {{(SW-drt_pkg::IN_CW){in_tdata[15]}}, in_tdata[15:0]};
  assign t_s = {{(SW-drt_pkg::IN_CW){in_tdata[31]}}, in_tdata[31:16]};
  assign r_s = {{(SW-drt_pkg::IN_CW){in_tdata[47]}}, in_tdata[47:32]};
  assign b_s = {{(SW-drt_pkg::IN_CW){in_tdata[63]}}, in_tdata[63:48]};

  assign lc_s = l_s[SW-1] ? '0 : l_s;
  assign tc_s = t_s[SW-1] ? '0 : t_s;
  assign rc_s = (r_s > mx_s) ? mx_s : r_s;
  assign bc_s = (b_s > my_s) ? my_s : b_s;

  assign rect_empty = (lc_s > rc_s) || (tc_s > bc_s);
  assign clamped    = {bc_s[CB-1:0], rc_s[CB-1:0], tc_s[CB-1:0], lc_s[CB-1:0]};

  // Full-frame result, zero edge for a zero screen size
  assign full_rect = {my_s[SW-1] ? {CB{1'b0}} : my_s[CB-1:0],
                      mx_s[SW-1] ? {CB{1'b0}} : mx_s[CB-1:0],
                      {CB{1'b0}}, {CB{1'b0}}};

  drt_merge #(
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .new_rect (rect_r),
    .ent_rect (rd_data_r),
    .hit      (hit),
    .merged   (merged)
  );

  assign idx_inc  = CW'(idx_r) + CW'(1);
  assign idx_last = (idx_inc == count_r);

  // Sequencer: scan, merge, append and drain
  always_comb begin
    state_nxt     = state_r;
    rect_nxt      = rect_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_rect_nxt  = out_rect_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = idx_r;
    mem_raddr     = '0;
    mem_wdata     = merged;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            drt_pkg::CMD_ADD: begin
              if (!rect_empty) begin
                rect_nxt = clamped;
                if (count_r == '0) begin
                  mem_we      = 1'b1;
                  mem_waddr   = '0;
                  mem_wdata   = clamped;
                  count_nxt   = CW'(1);
                  pending_nxt = 1'b1;
                end else begin
                  mem_re    = 1'b1;
                  idx_nxt   = '0;
                  state_nxt = ST_SCAN;
                end
              end
            end
            drt_pkg::CMD_FULL: begin
              pending_nxt = 1'b1;
              count_nxt   = '0;
            end
            drt_pkg::CMD_DRAIN: begin
              if (pending_r && (count_r != '0)) begin
                mem_re    = 1'b1;
                idx_nxt   = '0;
                state_nxt = ST_DRAIN;
              end else begin
                state_nxt = ST_EMIT;
              end
            end
            default: begin
              // unused command: drop
            end
          endcase
        end
      end

      ST_SCAN: begin
        priority if (hit) begin
          // grow the first overlapping entry
          mem_we      = 1'b1;
          mem_waddr   = idx_r;
          mem_wdata   = merged;
          pending_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (idx_last) begin
          // no overlap: append, or fall back to a full repaint
          if (count_r < CW'(MAX_REGIONS)) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[AW-1:0];
            mem_wdata = rect_r;
            count_nxt = count_r + CW'(1);
          end else begin
            count_nxt = '0;
          end
          pending_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[AW-1:0];
          idx_nxt   = idx_inc[AW-1:0];
        end
      end

      ST_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rect_nxt  = rd_data_r;
          out_kind_nxt  = drt_pkg::KIND_REGION;
          out_last_nxt  = idx_last;
          if (idx_last) begin
            pending_nxt = 1'b0;
            count_nxt   = '0;
            state_nxt   = ST_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_inc[AW-1:0];
            idx_nxt   = idx_inc[AW-1:0];
          end
        end else begin
          // hold the read data and address until the output frees up
          mem_raddr = idx_r;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rect_nxt  = pending_r ? full_rect : '0;
          out_kind_nxt  = pending_r ? drt_pkg::KIND_FULL : drt_pkg::KIND_NONE;
          out_last_nxt  = 1'b1;
          pending_nxt   = 1'b0;
          count_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pending_r   <= 1'b1;
      out_valid_r <= 1'b0;
      width_r     <= drt_pkg::SCREEN_WIDTH_RST;
      height_r    <= drt_pkg::SCREEN_HEIGHT_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          drt_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
          drt_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rect_r     <= rect_nxt;
    idx_r      <= idx_nxt;
    out_rect_r <= out_rect_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  // Region table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ODW'(out_rect_r);
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- hdl/drt_checker.sv -----
// Port-level checks for the dirty region tracker, bound to the top level.
// Depends on drt_pkg and dirty_region_tracker.
module drt_checker #(
  parameter int COORD_BITS = drt_pkg::COORD_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [drt_pkg::CMD_W-1:0]         in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((4*COORD_BITS+7)/8)*8-1:0] out_tdata,
  input logic [drt_pkg::KIND_W-1:0]        out_tuser,
  input logic                              out_tlast
);

  localparam int CB = COORD_BITS;

  logic [CB-1:0] o_left, o_top, o_right, o_bottom;

  assign o_left   = out_tdata[CB-1:0];
  assign o_top    = out_tdata[2*CB-1:CB];
  assign o_right  = out_tdata[3*CB-1:2*CB];
  assign o_bottom = out_tdata[4*CB-1:3*CB];

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Full-frame and nothing results stand alone in their run
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != drt_pkg::KIND_REGION) |-> out_tlast)
    else $error("single drain result without last mark");

  // Stored regions are never inverted
  a_region_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == drt_pkg::KIND_REGION)
      |-> (o_left <= o_right) && (o_top <= o_bottom))
    else $error("drained region has inverted edges");

  // Add and full repaint transactions never produce a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid && (in_tuser != drt_pkg::CMD_DRAIN)
      |=> !out_tvalid)
    else $error("result appeared without a drain");

endmodule

bind dirty_region_tracker drt_checker #(
  .COORD_BITS (COORD_BITS)
) u_drt_checker (.*);
